FILE: sv/epoch_seconds_to_datetime_assert.svh
// Assertion macros for the epoch seconds to date/time converter.
`ifndef EPOCH_SECONDS_TO_DATETIME_ASSERT_SVH
`define EPOCH_SECONDS_TO_DATETIME_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ESDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define ESDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/esdt_pkg.sv
// Constants, types and microcode ROM for the epoch seconds to date/time converter.
package esdt_pkg;

    localparam int SecW      = 31;
    localparam int InDataW   = 32;
    localparam int OutDataW  = 40;
    localparam int DaysW     = 16;
    localparam int YearW     = 11;
    localparam int MonW      = 4;
    localparam int DayW      = 5;
    localparam int HourW     = 5;
    localparam int MinW      = 6;
    localparam int SecFW     = 6;
    localparam int RemW      = 6;
    localparam int PcW       = 4;
    localparam int RecipW    = 32;
    localparam int ProdW     = SecW + RecipW;
    localparam int Recip60Sh = 37;
    localparam int Recip24Sh = 36;

    // ceil(2^37 / 60) and ceil(2^36 / 24): exact quotients for any 31-bit dividend
    localparam logic [RecipW-1:0] Recip60 = 32'd2290649225;
    localparam logic [RecipW-1:0] Recip24 = 32'd2863311531;

    localparam logic [YearW-1:0] EpochYear  = 11'd1970;
    localparam logic [1:0]       EpochY4    = 2'd2;
    localparam logic [6:0]       EpochY100  = 7'd70;
    localparam logic [8:0]       EpochY400  = 9'd370;

    localparam logic [PcW-1:0] ST_IDLE   = 4'd0;
    localparam logic [PcW-1:0] ST_DIV_S  = 4'd1;
    localparam logic [PcW-1:0] ST_SAV_S  = 4'd2;
    localparam logic [PcW-1:0] ST_DIV_M  = 4'd3;
    localparam logic [PcW-1:0] ST_SAV_M  = 4'd4;
    localparam logic [PcW-1:0] ST_DIV_H  = 4'd5;
    localparam logic [PcW-1:0] ST_SAV_H  = 4'd6;
    localparam logic [PcW-1:0] ST_YEAR   = 4'd7;
    localparam logic [PcW-1:0] ST_MONTH  = 4'd8;
    localparam logic [PcW-1:0] ST_EMIT   = 4'd9;

    typedef enum logic [2:0] {
        OP_WAIT_IN,
        OP_DIV,
        OP_SAVE_SEC,
        OP_SAVE_MIN,
        OP_SAVE_HOUR,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_YEAR_DONE,
        C_MONTH_DONE,
        C_OUT_FREE
    } t_cond;

    typedef enum logic {
        D60,
        D24
    } t_dsel;

    typedef struct packed {
        t_op              op;
        t_dsel            dsel;
        t_cond            cond;
        logic [PcW-1:0]   jmp;
    } t_uword;

    // jump to jmp when cond holds, otherwise stay on the step
    function automatic t_uword ucode(input logic [PcW-1:0] pc);
        t_uword w;
        unique case (pc)
            ST_IDLE:  w = '{OP_WAIT_IN,   D60, C_IN_VALID,   ST_DIV_S};
            ST_DIV_S: w = '{OP_DIV,       D60, C_ALWAYS,     ST_SAV_S};
            ST_SAV_S: w = '{OP_SAVE_SEC,  D60, C_ALWAYS,     ST_DIV_M};
            ST_DIV_M: w = '{OP_DIV,       D60, C_ALWAYS,     ST_SAV_M};
            ST_SAV_M: w = '{OP_SAVE_MIN,  D60, C_ALWAYS,     ST_DIV_H};
            ST_DIV_H: w = '{OP_DIV,       D24, C_ALWAYS,     ST_SAV_H};
            ST_SAV_H: w = '{OP_SAVE_HOUR, D24, C_ALWAYS,     ST_YEAR};
            ST_YEAR:  w = '{OP_YEAR,      D60, C_YEAR_DONE,  ST_MONTH};
            ST_MONTH: w = '{OP_MONTH,     D60, C_MONTH_DONE, ST_EMIT};
            ST_EMIT:  w = '{OP_EMIT,      D60, C_OUT_FREE,   ST_IDLE};
            default:  w = '{OP_WAIT_IN,   D60, C_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m,
                                                    input logic leap);
        logic [DayW-1:0] d;
        unique case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/epoch_seconds_to_datetime.sv
// Top level: microcoded converter from epoch seconds to calendar date and time.
// One request at a time; bit 31 of the input word is ignored. Seconds, minutes and hours
// come from a shared reciprocal multiplier (31 x 32 bit product) for division by 60, 60
// and 24, the quotient in one step and the remainder in the next; the day count is then
// walked one year per cycle from 1970 and one month per cycle. A finished result waits in
// the output register while the next request is accepted and processed; the emit step
// stalls while that register is full and not being read.
`include "epoch_seconds_to_datetime_assert.svh"

module epoch_seconds_to_datetime
    import esdt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // [30:0] epoch_seconds
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata    // [10:0] year, [14:11] month_of_year,
                                                // [19:15] day_of_month, [24:20] hour_of_day,
                                                // [30:25] minute_of_hour,
                                                // [36:31] second_of_minute
);

    logic [PcW-1:0]    r_pc;
    logic [SecW-1:0]   r_num;
    logic [SecW-1:0]   r_quo;
    logic [SecFW-1:0]  r_sec;
    logic [MinW-1:0]   r_min;
    logic [HourW-1:0]  r_hour;
    logic [DaysW-1:0]  r_days;
    logic [YearW-1:0]  r_year;
    logic [MonW-1:0]   r_month;
    logic [1:0]        r_y4;
    logic [6:0]        r_y100;
    logic [8:0]        r_y400;
    logic              r_out_valid;
    logic [OutDataW-1:0] r_out_data;

    t_uword            w_uw;
    logic [RecipW-1:0] w_recip;
    logic [ProdW-1:0]  w_prod;
    logic [SecW-1:0]   w_quo;
    logic [RemW-1:0]   w_qd;
    logic [RemW-1:0]   w_rem;
    logic              w_leap;
    logic [8:0]        w_ylen;
    logic [DayW-1:0]   w_mlen;
    logic              w_year_done;
    logic              w_month_done;
    logic              w_out_free;
    logic              w_emit;
    logic              w_res_ok;
    logic              w_cond;
    logic [DayW-1:0]   w_dom;
    logic [PcW-1:0]    n_pc;

    assign w_uw         = ucode(r_pc);
    assign w_recip      = (w_uw.dsel == D60) ? Recip60 : Recip24;
    assign w_prod       = ProdW'(r_num) * ProdW'(w_recip);
    assign w_quo        = (w_uw.dsel == D60) ? SecW'(w_prod[ProdW-1:Recip60Sh])
                                             : SecW'(w_prod[ProdW-1:Recip24Sh]);
    // remainder is below 60, so the low six bits of quotient * divisor suffice
    assign w_qd         = (w_uw.dsel == D60) ? (6'd0 - {r_quo[3:0], 2'b00})
                                             : ({r_quo[1:0], 4'b0000} + {r_quo[2:0], 3'b000});
    assign w_rem        = r_num[RemW-1:0] - w_qd;
    assign w_leap       = (r_y4 == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign w_ylen       = w_leap ? 9'd366 : 9'd365;
    assign w_mlen       = month_days(r_month, w_leap);
    assign w_year_done  = (r_days < DaysW'(w_ylen));
    assign w_month_done = (r_days < DaysW'(w_mlen)) || (r_month >= 4'd12);
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_emit       = (w_uw.op == OP_EMIT) && w_out_free;
    assign w_dom        = r_days[DayW-1:0] + 5'd1;
    assign w_res_ok     = (m_axis_tdata[14:11] >= 4'd1) && (m_axis_tdata[14:11] <= 4'd12) &&
                          (m_axis_tdata[19:15] != 5'd0) && (m_axis_tdata[24:20] < 5'd24);

    always_comb begin
        unique case (w_uw.cond)
            C_ALWAYS:     w_cond = 1'b1;
            C_IN_VALID:   w_cond = s_axis_tvalid;
            C_YEAR_DONE:  w_cond = w_year_done;
            C_MONTH_DONE: w_cond = w_month_done;
            C_OUT_FREE:   w_cond = w_out_free;
            default:      w_cond = 1'b1;
        endcase
        n_pc = w_cond ? w_uw.jmp : r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {3'b000, r_sec, r_min, r_hour, w_dom, r_month, r_year};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (w_uw.op)
                OP_WAIT_IN: begin
                    if (s_axis_tvalid) begin
                        r_num <= s_axis_tdata[SecW-1:0];
                    end
                end
                OP_DIV: begin
                    r_quo <= w_quo;
                end
                OP_SAVE_SEC: begin
                    r_sec <= w_rem;
                    r_num <= r_quo;
                end
                OP_SAVE_MIN: begin
                    r_min <= w_rem;
                    r_num <= r_quo;
                end
                OP_SAVE_HOUR: begin
                    r_hour  <= w_rem[HourW-1:0];
                    r_days  <= r_quo[DaysW-1:0];
                    r_year  <= EpochYear;
                    r_month <= 4'd1;
                    r_y4    <= EpochY4;
                    r_y100  <= EpochY100;
                    r_y400  <= EpochY400;
                end
                OP_YEAR: begin
                    if (!w_year_done) begin
                        r_days <= r_days - DaysW'(w_ylen);
                        r_year <= r_year + 11'd1;
                        r_y4   <= r_y4 + 2'd1;
                        r_y100 <= (r_y100 == 7'd99)  ? 7'd0 : r_y100 + 7'd1;
                        r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                    end
                end
                OP_MONTH: begin
                    if (!w_month_done) begin
                        r_days  <= r_days - DaysW'(w_mlen);
                        r_month <= r_month + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = i_rst_n && (w_uw.op == OP_WAIT_IN);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ESDT_ASSERT_NOW(a_out_range, m_axis_tvalid, w_res_ok, "result field out of range")
    `ESDT_ASSERT_NEXT(a_out_hold, !w_out_free, m_axis_tvalid && $stable(m_axis_tdata), "stalled result lost")
    `ESDT_ASSERT_NEXT(a_emit, w_emit, m_axis_tvalid && (r_pc == ST_IDLE), "result not loaded")

endmodule

FILE: dv/epoch_seconds_to_datetime_test.sv
// Self-checking testbench for the epoch seconds to date/time converter, random stalls on both sides.
module epoch_seconds_to_datetime_test;
    timeunit 1ns;
    timeprecision 1ps;

    import esdt_pkg::*;

    localparam int MonLsb  = YearW;
    localparam int DayLsb  = MonLsb + MonW;
    localparam int HourLsb = DayLsb + DayW;
    localparam int MinLsb  = HourLsb + HourW;
    localparam int SecLsb  = MinLsb + MinW;

    localparam int RandomItems = 1320;
    localparam int HoldCycles  = 600;
    localparam int DrainCycles = 250;
    localparam int StuckLimit  = 20000;

    typedef struct packed {
        logic [YearW-1:0] year;
        logic [MonW-1:0]  month;
        logic [DayW-1:0]  day;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecFW-1:0] second;
    } t_datetime;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned year_length(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    class t_datetime_scoreboard;
        t_datetime pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function t_datetime to_datetime(input logic [SecW-1:0] secs);
            t_datetime   dt;
            int unsigned rest;
            int unsigned days;
            int unsigned yr;
            int unsigned mo;
            rest      = 32'(secs);
            dt.second = SecFW'(rest % 60);
            rest      = rest / 60;
            dt.minute = MinW'(rest % 60);
            rest      = rest / 60;
            dt.hour   = HourW'(rest % 24);
            days      = rest / 24;
            yr        = 1970;
            while (days >= year_length(yr)) begin
                days = days - year_length(yr);
                yr++;
            end
            mo = 1;
            while (mo < 12 && days >= month_length(yr, mo)) begin
                days = days - month_length(yr, mo);
                mo++;
            end
            dt.year  = YearW'(yr);
            dt.month = MonW'(mo);
            dt.day   = DayW'(days + 1);
            return dt;
        endfunction

        function void note_request(input logic [InDataW-1:0] word);
            pending.push_back(to_datetime(word[SecW-1:0]));
        endfunction

        task report(input string what);
            $display("%0t: mismatch: %s", $time, what);
            errors++;
        endtask

        task compare_field(input string name, input int unsigned got, input int unsigned want);
            if (got != want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(input logic [OutDataW-1:0] word);
            t_datetime want;
            if (pending.size() == 0) begin
                report($sformatf("result %h with no request outstanding", word));
                return;
            end
            want = pending.pop_front();
            compare_field("year",   32'(word[YearW-1:0]),        32'(want.year));
            compare_field("month",  32'(word[MonLsb +: MonW]),   32'(want.month));
            compare_field("day",    32'(word[DayLsb +: DayW]),   32'(want.day));
            compare_field("hour",   32'(word[HourLsb +: HourW]), 32'(want.hour));
            compare_field("minute", 32'(word[MinLsb +: MinW]),   32'(want.minute));
            compare_field("second", 32'(word[SecLsb +: SecFW]),  32'(want.second));
        endtask
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tready = 1'b0;
    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [OutDataW-1:0] m_axis_tdata;

    t_datetime_scoreboard scoreboard = new();
    bit calm        = 1'b0;
    bit hold_output = 1'b0;
    int stuck_cycles = 0;

    // minute/hour/day edges, month ends (30/31/28 days), year ends, leap Feb, max, bit 31 set
    logic [InDataW-1:0] corner_seconds [0:21] = '{
        32'd0,         32'd59,        32'd60,        32'd3599,
        32'd3600,      32'd86399,     32'd86400,     32'd2678399,
        32'd2678400,   32'd10367999,  32'd10368000,  32'd31535999,
        32'd31536000,  32'd68169599,  32'd68169600,  32'd99791999,
        32'd946684799, 32'd951782400, 32'd978307199, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF
    };

    epoch_seconds_to_datetime u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5ns i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                scoreboard.note_request(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                scoreboard.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= StuckLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [InDataW-1:0] pick_seconds();
        logic [InDataW-1:0] word;
        int unsigned        days;
        int unsigned        base;
        int unsigned        yr;
        int unsigned        mo;
        word = '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                word[SecW-1:0]    = SecW'($urandom);
                word[InDataW-1]   = ($urandom_range(0, 7) == 0);
            end
            4, 5, 6, 7: begin
                // around the start of a random month
                yr   = $urandom_range(1970, 2037);
                mo   = $urandom_range(1, 12);
                days = 0;
                for (int unsigned y = 1970; y < yr; y++)
                    days += year_length(y);
                for (int unsigned m = 1; m < mo; m++)
                    days += month_length(yr, m);
                base = days * 86400;
                case ($urandom_range(0, 3))
                    0:       base = (base > 0) ? base - 1 : base;
                    1:       base = base;
                    2:       base = base + 86399;
                    default: base = (base >= 86400) ? base - 86400 : base;
                endcase
                word[SecW-1:0] = SecW'(base);
            end
            default: word[SecW-1:0] = SecW'($urandom_range(0, 3000000));
        endcase
        return word;
    endfunction

    task automatic send_request(input logic [InDataW-1:0] word);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (scoreboard.pending.size() != 0);
    endtask

    initial begin
        forever begin
            if (hold_output) begin
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_output = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_seconds[i])
            send_request(corner_seconds[i]);
        wait_for_results();

        for (int n = 0; n < RandomItems; n++) begin
            if (n == 100) begin
                // output held off, input kept busy until the block backs up
                hold_output = 1'b1;
                calm        = 1'b1;
                repeat (8) send_request(pick_seconds());
                calm        = 1'b0;
            end
            if (n == 700)
                wait_for_results();
            if (n == RandomItems - 200)
                calm = 1'b1;
            send_request(pick_seconds());
        end

        wait_for_results();
        repeat (DrainCycles) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
